### rtl/two_tap_adpcm_frame_decoder_unit_macros.svh
// Assertion macros used by the frame decoder's top-level RTL file.
`ifndef TWO_TAP_ADPCM_FRAME_DECODER_UNIT_MACROS_SVH
`define TWO_TAP_ADPCM_FRAME_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTAFD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTAFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ttafd_pkg.sv
// Shared types, constants and the coefficient table of the frame decoder.
`default_nettype none

package ttafd_pkg;

  // Header byte that marks an uncompressed frame.
  localparam logic [7:0] HDR_RAW = 8'hEE;

  // Byte positions within a frame.
  localparam logic [5:0] POS_HEADER     = 6'd0;
  localparam logic [5:0] POS_HIST_ONE   = 6'd2;
  localparam logic [5:0] POS_HIST_TWO   = 6'd4;
  localparam logic [5:0] RAW_LAST_POS   = 6'd60;
  localparam logic [5:0] ADPCM_LAST_POS = 6'd14;

  // The nibble shift is the header low nibble plus this base.
  localparam logic [4:0] NIBBLE_SHIFT_BASE = 5'd8;
  // A nibble is scaled by two to the power of this, less the nibble shift.
  localparam logic [4:0] SCALE_EXP = 5'd28;

  localparam int ACC_W  = 48;
  localparam int SEED_W = 24;

  typedef struct packed {
    logic signed [15:0] c1;
    logic signed [15:0] c2;
  } tap_pair_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic load;     // accumulator takes the scaled nibble
    logic accum;    // accumulator adds the registered product
    logic tap_two;  // multiply the second tap rather than the first
  } mac_ctrl_t;

  // Coefficient pairs; predictor codes fourteen and fifteen give zero.
  function automatic tap_pair_t tap_pair(input logic [3:0] sel);
    tap_pair_t t;
    t.c1 = 16'sd0;
    t.c2 = 16'sd0;
    case (sel)
      4'd1:  t.c1 = 16'sd240;
      4'd2: begin
        t.c1 = 16'sd460;
        t.c2 = -16'sd208;
      end
      4'd3: begin
        t.c1 = 16'sd392;
        t.c2 = -16'sd220;
      end
      4'd5:  t.c1 = 16'sd240;
      4'd6:  t.c1 = 16'sd460;
      4'd7:  t.c1 = 16'sd392;
      4'd10: begin
        t.c1 = -16'sd208;
        t.c2 = -16'sd1;
      end
      4'd11: begin
        t.c1 = -16'sd220;
        t.c2 = -16'sd1;
      end
      4'd13: t.c2 = 16'sd16240;
      default: begin
        t.c1 = 16'sd0;
        t.c2 = 16'sd0;
      end
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

### rtl/ttafd_byte_if.sv
// Handshake channel that carries one frame stream byte per beat.
`default_nettype none

interface ttafd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

### rtl/ttafd_pcm_if.sv
// Handshake channel that carries one decoded PCM sample per beat.
`default_nettype none

interface ttafd_pcm_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic               frame_end;
  logic               raw_frame;

  modport source (output valid, output pcm_sample, output frame_end, output raw_frame,
                  input ready);
  modport sink (input valid, input pcm_sample, input frame_end, input raw_frame,
                output ready);
endinterface

`default_nettype wire

### rtl/ttafd_mac.sv
// Shared multiply-accumulate unit that forms one predicted sample from a seed and two taps.
`default_nettype none

module ttafd_mac (
  input  wire logic                              clk,
  input  wire ttafd_pkg::mac_ctrl_t              ctrl,
  input  wire ttafd_pkg::tap_pair_t              taps,
  input  wire logic signed [31:0]                history_one,
  input  wire logic signed [31:0]                history_two,
  input  wire logic signed [ttafd_pkg::SEED_W-1:0] seed,
  output logic signed [ttafd_pkg::ACC_W-1:0]     acc
);
  import ttafd_pkg::*;

  logic signed [31:0]    operand;
  logic signed [15:0]    coef;
  logic signed [ACC_W-1:0] prod;

  // Pick the tap that the sequencer asks for.
  assign operand = ctrl.tap_two ? history_two : history_one;
  assign coef    = ctrl.tap_two ? taps.c2 : taps.c1;

  // The product is registered before it meets the adder.
  always_ff @(posedge clk) begin
    prod <= operand * coef;
    if (ctrl.load) begin
      acc <= {{(ACC_W-SEED_W){seed[SEED_W-1]}}, seed};
    end else if (ctrl.accum) begin
      acc <= acc + prod;
    end
  end

endmodule

`default_nettype wire

### rtl/two_tap_adpcm_frame_decoder_unit.sv
// Top level of the two-tap ADPCM frame decoder: byte sequencer and sample output.
//
//   channel       direction  beat payload
//   frame_bytes   in         data_byte (8 bits), header byte first
//   samples       out        pcm_sample (16 bits signed), frame_end, raw_frame
//
// Header, history and high sample bytes are taken in the idle state alone; a low sample
// byte also passes through the raw output state. An ADPCM data byte, once accepted, runs
// each nibble through the shared multiply-accumulate unit (load, first tap, second tap, write back).
// Synchronous reset clears the frame position, histories and header fields (the nibble shift returns to its base).
// An output register that is not taken holds the sequencer in its write-back or raw
// output state; the next byte is accepted while the last sample still waits.
`default_nettype none

module two_tap_adpcm_frame_decoder_unit (
  input wire logic    clk,
  input wire logic    rst,
  ttafd_byte_if.sink  frame_bytes,
  ttafd_pcm_if.source samples
);
  import ttafd_pkg::*;
  `include "two_tap_adpcm_frame_decoder_unit_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_ADD,
    ST_EMIT,
    ST_RAW
  } state_t;

  state_t             state;
  logic [5:0]         pos;
  logic               frame_is_raw;
  logic [3:0]         predictor_select;
  logic [4:0]         nibble_shift;
  logic signed [31:0] history_one;
  logic signed [31:0] history_two;
  logic [7:0]         high_byte_hold;
  logic [7:0]         cur_byte;
  logic               second_nibble;
  logic               end_pend;
  logic [15:0]        raw_word;

  logic               out_valid;
  logic signed [15:0] out_pcm;
  logic               out_end;
  logic               out_raw;

  logic                    accept;
  logic                    slot_free;
  logic                    load_out;
  logic [3:0]              nib;
  logic [4:0]              scale_shift;
  logic signed [SEED_W-1:0] seed;
  mac_ctrl_t               mac_ctrl;
  tap_pair_t               taps;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0]      v_wrap;
  logic signed [15:0]      v_clamp;

  // Handshake.
  assign frame_bytes.ready  = (state == ST_IDLE);
  assign accept             = frame_bytes.valid && frame_bytes.ready;
  assign slot_free          = !out_valid || samples.ready;
  assign load_out           = ((state == ST_EMIT) || (state == ST_RAW)) && slot_free;
  assign samples.valid      = out_valid;
  assign samples.pcm_sample = out_pcm;
  assign samples.frame_end  = out_end;
  assign samples.raw_frame  = out_raw;

  // Scaled nibble that seeds the accumulator.
  assign nib         = second_nibble ? cur_byte[3:0] : cur_byte[7:4];
  assign scale_shift = SCALE_EXP - nibble_shift;
  assign seed        = {{(SEED_W-4){nib[3]}}, nib} <<< scale_shift;
  assign taps        = tap_pair(predictor_select);

  // Sequencer drives the shared unit.
  always_comb begin
    mac_ctrl = '0;
    case (state)
      ST_MUL1: mac_ctrl.load = 1'b1;
      ST_MUL2: begin
        mac_ctrl.accum   = 1'b1;
        mac_ctrl.tap_two = 1'b1;
      end
      ST_ADD:  mac_ctrl.accum = 1'b1;
      default: mac_ctrl = '0;
    endcase
  end

  ttafd_mac u_mac (
    .clk         (clk),
    .ctrl        (mac_ctrl),
    .taps        (taps),
    .history_one (history_one),
    .history_two (history_two),
    .seed        (seed),
    .acc         (acc)
  );

  // Divide by 256 with flooring, wrap to 32 bits, then clamp to 16 bits.
  assign v_wrap = acc[39:8];
  always_comb begin
    if (!v_wrap[31] && (v_wrap[30:15] != 16'h0000)) begin
      v_clamp = 16'sh7FFF;
    end else if (v_wrap[31] && (v_wrap[30:15] != 16'hFFFF)) begin
      v_clamp = 16'sh8000;
    end else begin
      v_clamp = v_wrap[15:0];
    end
  end

  // Frame state, histories and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      pos              <= POS_HEADER;
      frame_is_raw     <= 1'b0;
      predictor_select <= 4'd0;
      nibble_shift     <= NIBBLE_SHIFT_BASE;
      history_one      <= 32'sd0;
      history_two      <= 32'sd0;
      high_byte_hold   <= 8'd0;
      second_nibble    <= 1'b0;
      end_pend         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      // The output register fills when a sample is loaded and empties when its beat is taken.
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (samples.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (pos == POS_HEADER) begin
              frame_is_raw <= (frame_bytes.data_byte == HDR_RAW);
              if (frame_bytes.data_byte != HDR_RAW) begin
                predictor_select <= frame_bytes.data_byte[7:4];
                nibble_shift     <= {1'b0, frame_bytes.data_byte[3:0]} + NIBBLE_SHIFT_BASE;
              end
              pos <= pos + 6'd1;
            end else if (frame_is_raw) begin
              if (pos[0]) begin
                high_byte_hold <= frame_bytes.data_byte;
                pos            <= pos + 6'd1;
              end else if (pos == POS_HIST_ONE) begin
                history_one <= {{16{high_byte_hold[7]}}, high_byte_hold,
                                frame_bytes.data_byte};
                pos         <= pos + 6'd1;
              end else if (pos == POS_HIST_TWO) begin
                history_two <= {{16{high_byte_hold[7]}}, high_byte_hold,
                                frame_bytes.data_byte};
                pos         <= pos + 6'd1;
              end else begin
                raw_word <= {high_byte_hold, frame_bytes.data_byte};
                end_pend <= (pos >= RAW_LAST_POS);
                pos      <= (pos >= RAW_LAST_POS) ? POS_HEADER : pos + 6'd1;
                state    <= ST_RAW;
              end
            end else begin
              cur_byte      <= frame_bytes.data_byte;
              second_nibble <= 1'b0;
              end_pend      <= (pos >= ADPCM_LAST_POS);
              pos           <= (pos >= ADPCM_LAST_POS) ? POS_HEADER : pos + 6'd1;
              state         <= ST_MUL1;
            end
          end
        end
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_ADD;
        ST_ADD:  state <= ST_EMIT;
        ST_EMIT: begin
          if (slot_free) begin
            out_pcm     <= v_clamp;
            out_end     <= second_nibble && end_pend;
            out_raw     <= 1'b0;
            history_two <= history_one;
            history_one <= v_wrap;
            if (second_nibble) begin
              state <= ST_IDLE;
            end else begin
              second_nibble <= 1'b1;
              state         <= ST_MUL1;
            end
          end
        end
        ST_RAW: begin
          if (slot_free) begin
            out_pcm   <= raw_word;
            out_end   <= end_pend;
            out_raw   <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  `TTAFD_ASSERT_IMP(a_pos_range, clk, rst, 1'b1, pos <= RAW_LAST_POS, "frame position out of range")
  `TTAFD_ASSERT_NEXT(a_adpcm_start, clk, rst, accept && (pos != POS_HEADER) && !frame_is_raw, (state == ST_MUL1) && !second_nibble, "ADPCM byte did not start on its first nibble")
  `TTAFD_ASSERT_NEXT(a_mac_order, clk, rst, state == ST_MUL1, state == ST_MUL2, "multiply sequence broken")
  `TTAFD_ASSERT_NEXT(a_second_done, clk, rst, (state == ST_EMIT) && slot_free && second_nibble, (state == ST_IDLE) && out_valid && !out_raw, "second nibble not delivered")

endmodule

`default_nettype wire
